/* src/spam_pkg.sv */
// shared types, opcodes and defaults for the sparse polynomial add/merge block
package spam_pkg;

   // default list depth
   localparam int MAX_TERMS_DEFAULT = 32;

   // field widths fixed by the interface
   localparam int COEF_W = 32;
   localparam int EXP_W  = 16;
   localparam int SUM_W  = COEF_W + 1;
   localparam int OP_W   = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE       = 2'd2;

   // input item
   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } req_item_type;

   // result item
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_coefficient;
      logic [EXP_W-1:0]        sum_exponent;
      logic                    last_term;
      logic                    empty_sum;
      logic                    dropped_terms;
   } rsp_item_type;

   // one stored term
   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } term_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

/* src/sparse_polynomial_add_merge_core.sv */
// top level: two term memories and the merge sequencer
//
// Sparse polynomial adder. Items arrive on the req_ channel (valid/ready):
// operation load-first or load-second stores one term at the tail of its
// list, operation merge walks both lists in descending exponent order and
// sends one result item per output term on the rsp_ channel (valid/ready).
// Equal exponents are combined into one term with the 33-bit exact sum;
// the final term of a merge carries last_term. A merge of two empty lists
// gives one item with empty_sum and last_term set. Loads into a full list
// are dropped and flagged on every term of the next merge.
// Steps: a load is written into its term memory when it is accepted. A merge
// produces each output term by a synchronous read of both term memories
// (ST_READ) and then a compare-and-emit step (ST_EMIT); an empty sum also
// goes through the read and emit steps. New items are accepted only while
// no merge is running; a load may enter while the last result still waits.
// When the receiver stalls, the result register holds and the merge pauses
// in its emit step until the slot frees up.
// Reset clears both list counts, the dropped flag and the result slot; the
// term memories need no clearing since only entries below a count are used.
module sparse_polynomial_add_merge_core #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  spam_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spam_pkg::rsp_item_type rsp_item
);
   import spam_pkg::*;

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic [CNT_W-1:0] first_idx_ff, first_idx_in;
   logic [CNT_W-1:0] second_idx_ff, second_idx_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   // term memories
   term_type         first_mem [MAX_TERMS];
   term_type         second_mem [MAX_TERMS];
   term_type         first_rd_ff;
   term_type         second_rd_ff;
   logic             first_wr_en;
   logic             second_wr_en;
   term_type         wr_term;
   logic [IDX_W-1:0] first_rd_addr;
   logic [IDX_W-1:0] second_rd_addr;

   // merge datapath
   logic                    accept;
   logic                    out_free;
   logic                    emit_fire;
   logic                    all_empty;
   logic                    first_has;
   logic                    second_has;
   logic                    pick_first;
   logic                    pick_second;
   logic                    merge_done;
   logic signed [SUM_W-1:0] first_wide;
   logic signed [SUM_W-1:0] second_wide;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;
   assign all_empty = (first_count_ff == '0) && (second_count_ff == '0);

   // merge comparison on the terms read last cycle
   assign first_has   = first_idx_ff < first_count_ff;
   assign second_has  = second_idx_ff < second_count_ff;
   assign pick_first  = !second_has ||
                        (first_has && (first_rd_ff.exponent > second_rd_ff.exponent));
   assign pick_second = !pick_first &&
                        (!first_has || (first_rd_ff.exponent < second_rd_ff.exponent));
   assign first_wide  = {first_rd_ff.coefficient[COEF_W-1], first_rd_ff.coefficient};
   assign second_wide = {second_rd_ff.coefficient[COEF_W-1], second_rd_ff.coefficient};

   // read addresses, held in range past the end of a list
   assign first_rd_addr  = (first_idx_ff < CNT_MAX) ? first_idx_ff[IDX_W-1:0] : '0;
   assign second_rd_addr = (second_idx_ff < CNT_MAX) ? second_idx_ff[IDX_W-1:0] : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.operation == OP_MERGE)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = merge_done ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs, list bookkeeping and result slot
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      first_idx_in    = first_idx_ff;
      second_idx_in   = second_idx_ff;
      overflow_in     = overflow_ff;
      first_wr_en     = 1'b0;
      second_wr_en    = 1'b0;
      wr_term         = '{coefficient: req_item.coefficient, exponent: req_item.exponent};
      merge_done      = 1'b0;
      rsp_item_in     = rsp_item_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      // loads
      if (accept) begin
         unique case (req_item.operation)
            OP_LOAD_FIRST: begin
               if (first_count_ff < CNT_MAX) begin
                  first_wr_en    = 1'b1;
                  first_count_in = first_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            OP_LOAD_SECOND: begin
               if (second_count_ff < CNT_MAX) begin
                  second_wr_en    = 1'b1;
                  second_count_in = second_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // emit one merged term
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         if (all_empty) begin
            rsp_item_in = '0;
            rsp_item_in.empty_sum = 1'b1;
            merge_done = 1'b1;
         end else begin
            rsp_item_in.empty_sum     = 1'b0;
            rsp_item_in.dropped_terms = overflow_ff;
            if (pick_first) begin
               rsp_item_in.sum_coefficient = first_wide;
               rsp_item_in.sum_exponent    = first_rd_ff.exponent;
               first_idx_in = first_idx_ff + 1'b1;
            end else if (pick_second) begin
               rsp_item_in.sum_coefficient = second_wide;
               rsp_item_in.sum_exponent    = second_rd_ff.exponent;
               second_idx_in = second_idx_ff + 1'b1;
            end else begin
               rsp_item_in.sum_coefficient = first_wide + second_wide;
               rsp_item_in.sum_exponent    = first_rd_ff.exponent;
               first_idx_in  = first_idx_ff + 1'b1;
               second_idx_in = second_idx_ff + 1'b1;
            end
            merge_done = !(first_idx_in < first_count_ff) &&
                         !(second_idx_in < second_count_ff);
         end
         rsp_item_in.last_term = merge_done;
         // both lists clear at the end of a merge
         if (merge_done) begin
            first_count_in  = '0;
            second_count_in = '0;
            first_idx_in    = '0;
            second_idx_in   = '0;
            overflow_in     = 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_idx_ff    <= '0;
         second_idx_ff   <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_idx_ff    <= first_idx_in;
         second_idx_ff   <= second_idx_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // first list memory
   always_ff @(posedge clock) begin
      if (first_wr_en) begin
         first_mem[first_count_ff[IDX_W-1:0]] <= wr_term;
      end
      first_rd_ff <= first_mem[first_rd_addr];
   end

   // second list memory
   always_ff @(posedge clock) begin
      if (second_wr_en) begin
         second_mem[second_count_ff[IDX_W-1:0]] <= wr_term;
      end
      second_rd_ff <= second_mem[second_rd_addr];
   end

   // counts never pass the list depth
   assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= CNT_MAX) && (second_count_ff <= CNT_MAX))
      else $error("list count beyond depth");

   // a non-empty emit always has a term left in some list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !all_empty) |-> (first_has || second_has))
      else $error("merge emit with both lists exhausted");

   // the last term of a merge leaves the block idle with cleared lists
   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && merge_done) |=>
         (state_ff == ST_IDLE && first_count_ff == '0 && second_count_ff == '0 &&
          !overflow_ff && rsp_item_ff.last_term))
      else $error("merge end did not clear state");

   // an empty result is a lone zero last term
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.empty_sum) |->
         (rsp_item_ff.last_term && rsp_item_ff.sum_coefficient == '0 &&
          rsp_item_ff.sum_exponent == '0 && !rsp_item_ff.dropped_terms))
      else $error("malformed empty result");

endmodule
